// File: design/cwh_pkg.sv
// ----------------------------------------------------------------------------
// cwh_pkg
// Shared widths, register codes and the front-to-back item format of the
// cylinder wall hit test.
// ----------------------------------------------------------------------------
package cwh_pkg;

  localparam int REG_BITS     = 23;
  localparam int REG_IDX_BITS = 2;
  // horizontal offsets of 2^MAG_BITS or more never hit
  localparam int MAG_BITS     = 25;
  localparam int D2_BITS      = 2 * MAG_BITS + 1;
  localparam int ROOT_BITS    = 26;
  localparam int REM_BITS     = ROOT_BITS + 2;
  localparam int RAD_BITS     = REG_BITS + 2;

  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_INNER  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WALL   = 2'd2;

  localparam logic [REG_BITS-1:0] HEIGHT_RST = 23'd65536;
  localparam logic [REG_BITS-1:0] INNER_RST  = 23'd32768;
  localparam logic [REG_BITS-1:0] WALL_RST   = 23'd6554;

  localparam int QDEPTH   = 4;
  localparam int QPTR_BITS = 2;

  typedef struct packed {
    logic hit;
    logic near;
    logic neg_x;
    logic neg_z;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [MAG_BITS-1:0]  mag_x;
    logic [MAG_BITS-1:0]  mag_z;
    logic [D2_BITS-1:0]   d2;
  } cls_t;

endpackage

// File: design/cwh_front.sv
// ----------------------------------------------------------------------------
// cwh_front
// Takes test items, forms the offsets, runs the height, range and shell
// tests and hands a classified item to the queue.
// ----------------------------------------------------------------------------
module cwh_front #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         base_x,
  input  logic signed [COORD_BITS-1:0]         base_y,
  input  logic signed [COORD_BITS-1:0]         base_z,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         point_z,
  input  logic [cwh_pkg::REG_BITS-1:0]         height,
  input  logic [cwh_pkg::REG_BITS-1:0]         inner,
  input  logic [cwh_pkg::REG_BITS-1:0]         wall,
  output logic                                 q_push,
  input  logic                                 q_full,
  output cwh_pkg::cls_t                        q_cls,
  output logic [COORD_BITS-1:0]                q_bx,
  output logic [COORD_BITS-1:0]                q_bz,
  output logic [COORD_BITS-1:0]                q_py
);

  localparam int ONE     = 1 << FRAC_BITS;
  localparam int C_0P4   = (4 * ONE + 5) / 10;
  localparam int C_0P001 = (ONE + 500) / 1000;
  localparam int NEAR_SQ = C_0P001 * C_0P001;
  localparam int XW      = (COORD_BITS + 1 > 27) ? COORD_BITS + 1 : 27;
  localparam int TW      = (COORD_BITS + 2 > 25) ? COORD_BITS + 2 : 25;
  localparam int MB      = cwh_pkg::MAG_BITS;
  localparam int DB      = cwh_pkg::D2_BITS;

  logic signed [XW-1:0] dx, dz;
  logic [XW-1:0]        abs_x, abs_z;
  logic signed [TW-1:0] by_e, py_e, top_y;
  logic                 in_h, far, fen;

  logic                  v1_r, hv1_r, nx1_r, nz1_r;
  logic [MB-1:0]         mx1_r, mz1_r;
  logic [COORD_BITS-1:0] bx1_r, bz1_r, py1_r;
  logic                  v2_r, hv2_r, nx2_r, nz2_r;
  logic [MB-1:0]         mx2_r, mz2_r;
  logic [2*MB-1:0]       sqx2_r, sqz2_r;
  logic [COORD_BITS-1:0] bx2_r, bz2_r, py2_r;
  logic                  v3_r;
  cwh_pkg::cls_t         cls3_r;
  logic [COORD_BITS-1:0] bx3_r, bz3_r, py3_r;
  logic [DB-1:0]         isq_r, osq_r;
  logic [cwh_pkg::REG_BITS:0] outer;
  logic [DB-1:0]         d2;

  assign dx    = XW'(point_x) - XW'(base_x);
  assign dz    = XW'(point_z) - XW'(base_z);
  assign abs_x = dx[XW-1] ? -dx : dx;
  assign abs_z = dz[XW-1] ? -dz : dz;
  assign far   = (|abs_x[XW-1:MB]) || (|abs_z[XW-1:MB]);

  assign by_e  = TW'(base_y);
  assign py_e  = TW'(point_y);
  assign top_y = by_e + $signed({{(TW - cwh_pkg::REG_BITS){1'b0}}, height}) - TW'(C_0P4);
  assign in_h  = (py_e >= by_e) && (py_e < top_y);

  assign outer = {1'b0, inner} + {1'b0, wall};

  // stall the whole front while the last stage waits on a full queue
  assign fen      = !v3_r || !q_full;
  assign in_ready = fen;
  assign q_push   = v3_r && !q_full;

  always_ff @(posedge clk) begin
    isq_r <= DB'(inner) * DB'(inner);
    osq_r <= DB'(outer) * DB'(outer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (fen) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign d2 = DB'(sqx2_r) + DB'(sqz2_r);

  always_ff @(posedge clk) begin
    if (fen) begin
      hv1_r <= in_h && !far;
      nx1_r <= dx[XW-1];
      nz1_r <= dz[XW-1];
      mx1_r <= abs_x[MB-1:0];
      mz1_r <= abs_z[MB-1:0];
      bx1_r <= base_x;
      bz1_r <= base_z;
      py1_r <= point_y;

      hv2_r  <= hv1_r;
      nx2_r  <= nx1_r;
      nz2_r  <= nz1_r;
      mx2_r  <= mx1_r;
      mz2_r  <= mz1_r;
      sqx2_r <= mx1_r * mx1_r;
      sqz2_r <= mz1_r * mz1_r;
      bx2_r  <= bx1_r;
      bz2_r  <= bz1_r;
      py2_r  <= py1_r;

      cls3_r.ctl.hit   <= hv2_r && (d2 >= isq_r) && (d2 <= osq_r);
      cls3_r.ctl.near  <= d2 <= DB'(NEAR_SQ);
      cls3_r.ctl.neg_x <= nx2_r;
      cls3_r.ctl.neg_z <= nz2_r;
      cls3_r.mag_x     <= mx2_r;
      cls3_r.mag_z     <= mz2_r;
      cls3_r.d2        <= d2;
      bx3_r <= bx2_r;
      bz3_r <= bz2_r;
      py3_r <= py2_r;
    end
  end

  assign q_cls = cls3_r;
  assign q_bx  = bx3_r;
  assign q_bz  = bz3_r;
  assign q_py  = py3_r;

endmodule

// File: design/cwh_fifo.sv
// ----------------------------------------------------------------------------
// cwh_fifo
// Short first-word-fall-through queue between the front and the back.
// ----------------------------------------------------------------------------
module cwh_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);

  localparam int PB = cwh_pkg::QPTR_BITS;

  logic [W-1:0]  mem [cwh_pkg::QDEPTH];
  logic [PB-1:0] wr_r, rd_r;
  logic [PB:0]   cnt_r;
  logic          do_pop;

  assign full   = cnt_r == (PB + 1)'(cwh_pkg::QDEPTH);
  assign valid  = cnt_r != '0;
  assign do_pop = pop && valid;
  assign dout   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PB + 1)'(push) - (PB + 1)'(do_pop);
    end
  end

endmodule

// File: design/cwh_back.sv
// ----------------------------------------------------------------------------
// cwh_back
// Pipelined square root, two pipelined dividers for the unit direction,
// scaling to the push-out radius and saturation into the output register.
// ----------------------------------------------------------------------------
module cwh_back #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_pop,
  input  cwh_pkg::cls_t                        in_cls,
  input  logic [COORD_BITS-1:0]                in_bx,
  input  logic [COORD_BITS-1:0]                in_bz,
  input  logic [COORD_BITS-1:0]                in_py,
  input  logic [cwh_pkg::REG_BITS-1:0]         inner,
  input  logic [cwh_pkg::REG_BITS-1:0]         wall,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic signed [FRAC_BITS+1:0]          dir_x,
  output logic signed [FRAC_BITS+1:0]          dir_z,
  output logic signed [COORD_BITS-1:0]         push_x,
  output logic signed [COORD_BITS-1:0]         push_y,
  output logic signed [COORD_BITS-1:0]         push_z
);

  localparam int ONE   = 1 << FRAC_BITS;
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam int C_0P1 = (ONE + 5) / 10;
  localparam int RB    = cwh_pkg::ROOT_BITS;
  localparam int RMB   = cwh_pkg::REM_BITS;
  localparam int MB    = cwh_pkg::MAG_BITS;
  localparam int RDB   = cwh_pkg::RAD_BITS;
  localparam int NS    = RB;
  localparam int ND    = FRAC_BITS + 1;
  localparam int NW    = MB + FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int DW    = FRAC_BITS + 2;
  localparam int PRW   = QW + RDB;
  localparam int PW    = (COORD_BITS + 2 > RDB + 3) ? COORD_BITS + 2 : RDB + 3;
  localparam longint HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint LO = -HI - 64'sd1;

  logic ben;
  assign ben    = !out_valid || out_ready;
  assign in_pop = ben && in_valid;

  // square root stages
  logic                  sv    [NS+1];
  cwh_pkg::ctl_t         sctl  [NS+1];
  logic [MB-1:0]         smx   [NS+1];
  logic [MB-1:0]         smz   [NS+1];
  logic [COORD_BITS-1:0] sbx   [NS+1];
  logic [COORD_BITS-1:0] sbz   [NS+1];
  logic [COORD_BITS-1:0] spy   [NS+1];
  logic [RMB-1:0]        srem  [NS+1];
  logic [RB-1:0]         sroot [NS+1];
  logic [2*RB-1:0]       sval  [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv[0] <= 1'b0;
    else if (ben) sv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      sctl[0]  <= in_cls.ctl;
      smx[0]   <= in_cls.mag_x;
      smz[0]   <= in_cls.mag_z;
      sbx[0]   <= in_bx;
      sbz[0]   <= in_bz;
      spy[0]   <= in_py;
      srem[0]  <= '0;
      sroot[0] <= '0;
      sval[0]  <= (2 * RB)'(in_cls.d2);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [RMB-1:0] shr, trial;
    logic           ge;
    assign shr   = {srem[k][RMB-3:0], sval[k][2*RB-1 -: 2]};
    assign trial = {sroot[k], 2'b01};
    assign ge    = shr >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sv[k+1] <= 1'b0;
      else if (ben) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        sctl[k+1]  <= sctl[k];
        smx[k+1]   <= smx[k];
        smz[k+1]   <= smz[k];
        sbx[k+1]   <= sbx[k];
        sbz[k+1]   <= sbz[k];
        spy[k+1]   <= spy[k];
        srem[k+1]  <= ge ? shr - trial : shr;
        sroot[k+1] <= {sroot[k][RB-2:0], ge};
        sval[k+1]  <= sval[k] << 2;
      end
    end
  end

  // divider stages, one quotient bit each
  logic                  dv   [ND+1];
  cwh_pkg::ctl_t         dctl [ND+1];
  logic [COORD_BITS-1:0] dbx  [ND+1];
  logic [COORD_BITS-1:0] dbz  [ND+1];
  logic [COORD_BITS-1:0] dpy  [ND+1];
  logic [RB-1:0]         dr   [ND+1];
  logic [NW-1:0]         drx  [ND+1];
  logic [NW-1:0]         drz  [ND+1];
  logic [QW-1:0]         dqx  [ND+1];
  logic [QW-1:0]         dqz  [ND+1];

  logic [RB-1:0] root_nz;
  assign root_nz = (sroot[NS] == '0) ? RB'(1) : sroot[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) dv[0] <= 1'b0;
    else if (ben) dv[0] <= sv[NS];
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      dctl[0] <= sctl[NS];
      dbx[0]  <= sbx[NS];
      dbz[0]  <= sbz[NS];
      dpy[0]  <= spy[NS];
      dr[0]   <= root_nz;
      // round half up: add half the divisor before dividing
      drx[0]  <= (NW'(smx[NS]) << FRAC_BITS) + NW'(root_nz >> 1);
      drz[0]  <= (NW'(smz[NS]) << FRAC_BITS) + NW'(root_nz >> 1);
      dqx[0]  <= '0;
      dqz[0]  <= '0;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [NW-1:0] dvs;
    logic          gex, gez;
    assign dvs = NW'(dr[j]) << (FRAC_BITS - j);
    assign gex = drx[j] >= dvs;
    assign gez = drz[j] >= dvs;

    always_ff @(posedge clk) begin
      if (!rst_n) dv[j+1] <= 1'b0;
      else if (ben) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        dctl[j+1] <= dctl[j];
        dbx[j+1]  <= dbx[j];
        dbz[j+1]  <= dbz[j];
        dpy[j+1]  <= dpy[j];
        dr[j+1]   <= dr[j];
        drx[j+1]  <= gex ? drx[j] - dvs : drx[j];
        drz[j+1]  <= gez ? drz[j] - dvs : drz[j];
        dqx[j+1]  <= {dqx[j][QW-2:0], gex};
        dqz[j+1]  <= {dqz[j][QW-2:0], gez};
      end
    end
  end

  // direction and scale stage
  cwh_pkg::ctl_t   fctl;
  logic [QW-1:0]   mag_x, mag_z;
  logic [RDB-1:0]  rad;
  logic [PRW-1:0]  prod_x, prod_z;
  logic            neg_x, neg_z;

  assign fctl  = dctl[ND];
  assign mag_x = fctl.near ? QW'(ONE) : ((dqx[ND] > QW'(ONE)) ? QW'(ONE) : dqx[ND]);
  assign mag_z = fctl.near ? '0 : ((dqz[ND] > QW'(ONE)) ? QW'(ONE) : dqz[ND]);
  assign neg_x = fctl.neg_x && !fctl.near;
  assign neg_z = fctl.neg_z;
  assign rad   = RDB'(inner) + RDB'(wall) + RDB'(C_0P1);
  assign prod_x = PRW'(mag_x) * PRW'(rad) + PRW'(HALF);
  assign prod_z = PRW'(mag_z) * PRW'(rad) + PRW'(HALF);

  logic                  mv_r, mhit_r, mnx_r, mnz_r;
  logic signed [DW-1:0]  mdx_r, mdz_r;
  logic [RDB:0]          mpx_r, mpz_r;
  logic [COORD_BITS-1:0] mbx_r, mbz_r, mpy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (ben) mv_r <= dv[ND];
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      mhit_r <= fctl.hit;
      mnx_r  <= neg_x;
      mnz_r  <= neg_z;
      mdx_r  <= neg_x ? -$signed(DW'(mag_x)) : $signed(DW'(mag_x));
      mdz_r  <= neg_z ? -$signed(DW'(mag_z)) : $signed(DW'(mag_z));
      mpx_r  <= prod_x[PRW-1:FRAC_BITS];
      mpz_r  <= prod_z[PRW-1:FRAC_BITS];
      mbx_r  <= dbx[ND];
      mbz_r  <= dbz[ND];
      mpy_r  <= dpy[ND];
    end
  end

  // add to the base and clamp into the coordinate range
  logic signed [PW-1:0] sum_x, sum_z;
  logic signed [COORD_BITS-1:0] sat_x, sat_z;

  assign sum_x = PW'($signed(mbx_r)) + (mnx_r ? -$signed(PW'(mpx_r)) : $signed(PW'(mpx_r)));
  assign sum_z = PW'($signed(mbz_r)) + (mnz_r ? -$signed(PW'(mpz_r)) : $signed(PW'(mpz_r)));

  always_comb begin
    priority if (sum_x > $signed(PW'(HI))) sat_x = COORD_BITS'(HI);
    else if (sum_x < $signed(PW'(LO)))     sat_x = COORD_BITS'(LO);
    else                                   sat_x = sum_x[COORD_BITS-1:0];
    priority if (sum_z > $signed(PW'(HI))) sat_z = COORD_BITS'(HI);
    else if (sum_z < $signed(PW'(LO)))     sat_z = COORD_BITS'(LO);
    else                                   sat_z = sum_z[COORD_BITS-1:0];
  end

  logic ov_r;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ben) ov_r <= mv_r;
  end

  // zero every field on a miss
  always_ff @(posedge clk) begin
    if (ben) begin
      hit    <= mhit_r;
      dir_x  <= mhit_r ? mdx_r : '0;
      dir_z  <= mhit_r ? mdz_r : '0;
      push_x <= mhit_r ? sat_x : '0;
      push_y <= mhit_r ? $signed(mpy_r) : '0;
      push_z <= mhit_r ? sat_z : '0;
    end
  end

endmodule

// File: design/cylinder_wall_hit_and_pushout.sv
// ----------------------------------------------------------------------------
// cylinder_wall_hit_and_pushout
// Cylinder wall shell hit test with unit outward direction and push-out.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: base_x,y,z, point_x,y,z
//   out_     out  out_tvalid/out_tready out_tdata: dir_x,dir_z,push_x,y,z;
//                                       out_tuser: hit
//   cfg_     in   cfg_we                cfg_idx, cfg_wdata
//
// One test per cycle sustained while the output is not stalled. The path runs
// through three front stages, the queue, a load stage and a 26-stage square
// root, a load stage and a FRAC_BITS+1 stage divider pair, a scale stage and
// the output register.
// Reset clears all valid flags and restores the register defaults.
// A stalled output freezes the back pipeline; the front takes items until the
// four-entry queue is full and its last stage is loaded, then in_tready drops.
// ----------------------------------------------------------------------------
module cylinder_wall_hit_and_pushout #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // base_x, base_y, base_z, point_x, point_y, point_z
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // dir_x, dir_z, push_x, push_y, push_z
  output logic [((2*FRAC_BITS+4+3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // hit
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic [cwh_pkg::REG_IDX_BITS-1:0]   cfg_idx,
  input  logic [cwh_pkg::REG_BITS-1:0]       cfg_wdata
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((2*FRAC_BITS+4+3*COORD_BITS+7)/8)*8;
  localparam int QW    = $bits(cwh_pkg::cls_t) + 3 * COORD_BITS;

  logic [cwh_pkg::REG_BITS-1:0] height_r, inner_r, wall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= cwh_pkg::HEIGHT_RST;
      inner_r  <= cwh_pkg::INNER_RST;
      wall_r   <= cwh_pkg::WALL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cwh_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        cwh_pkg::REG_INNER:  inner_r  <= cfg_wdata;
        cwh_pkg::REG_WALL:   wall_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic                  q_push, q_full, q_pop, q_valid;
  cwh_pkg::cls_t         f_cls, b_cls;
  logic [C-1:0]          f_bx, f_bz, f_py, b_bx, b_bz, b_py;
  logic [QW-1:0]         q_din, q_dout;

  cwh_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .base_x   (in_tdata[C-1:0]),
    .base_y   (in_tdata[2*C-1:C]),
    .base_z   (in_tdata[3*C-1:2*C]),
    .point_x  (in_tdata[4*C-1:3*C]),
    .point_y  (in_tdata[5*C-1:4*C]),
    .point_z  (in_tdata[6*C-1:5*C]),
    .height   (height_r),
    .inner    (inner_r),
    .wall     (wall_r),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_cls    (f_cls),
    .q_bx     (f_bx),
    .q_bz     (f_bz),
    .q_py     (f_py)
  );

  assign q_din = {f_cls, f_bx, f_bz, f_py};
  assign {b_cls, b_bx, b_bz, b_py} = q_dout;

  cwh_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  logic                          hit;
  logic signed [FRAC_BITS+1:0]   dir_x, dir_z;
  logic signed [C-1:0]           push_x, push_y, push_z;

  cwh_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_cls    (b_cls),
    .in_bx     (b_bx),
    .in_bz     (b_bz),
    .in_py     (b_py),
    .inner     (inner_r),
    .wall      (wall_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .hit       (hit),
    .dir_x     (dir_x),
    .dir_z     (dir_z),
    .push_x    (push_x),
    .push_y    (push_y),
    .push_z    (push_z)
  );

  assign out_tdata = OUT_W'({push_z, push_y, push_x, dir_z, dir_x});
  assign out_tuser = hit;

endmodule

// File: design/cwh_check.sv
// ----------------------------------------------------------------------------
// cwh_check
// Port-level checks on the result channel of the wall hit block.
// ----------------------------------------------------------------------------
module cwh_check #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*FRAC_BITS+4+3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                         out_tuser
);

  localparam int ONE = 1 << FRAC_BITS;

  logic signed [FRAC_BITS+1:0] chk_dx, chk_dz;
  assign chk_dx = out_tdata[FRAC_BITS+1:0];
  assign chk_dz = out_tdata[2*FRAC_BITS+3:FRAC_BITS+2];

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss with nonzero fields");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      chk_dx <= ONE && chk_dx >= -ONE && chk_dz <= ONE && chk_dz >= -ONE)
    else $error("direction beyond unit length");

endmodule

bind cylinder_wall_hit_and_pushout cwh_check #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_cwh_check (.*);
